[rtl/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
`default_nettype none
package spq_pkg;

    localparam int DEPTH         = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int PRIO_W        = 8;
    localparam int CNT_W         = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_POP_HEAD = 2'd1,
        OP_POP_EXACT = 2'd2,
        OP_POP_AT_MOST = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        op_t                      op;
        logic [PRIO_W-1:0]        priority_req;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } req_beat_t;

    typedef struct packed {
        status_t                  status;
        logic [PAYLOAD_WIDTH-1:0] out_payload;
        logic [PRIO_W-1:0]        out_priority;
        logic [CNT_W-1:0]         fill;
    } rsp_beat_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage
`default_nettype wire

[rtl/spq_ctrl.sv]
// Handshake controller for the stable priority queue.
`default_nettype none
module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_stall,
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        req_stall = !((state_reg == S_IDLE) || ((state_reg == S_OUT) && !rsp_stall));
        accept    = req_valid && !req_stall;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = accept ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.capture = accept;
        cmd.execute = (state_reg == S_EXEC);
        rsp_valid   = (state_reg == S_OUT);
    end

`ifndef SYNTHESIS
    a_exec_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_OUT)
        else $error("execute cycle not followed by result");
    a_capture_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (state_reg == S_IDLE || state_reg == S_OUT))
        else $error("request captured while busy");
    a_no_capture_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> !cmd.capture)
        else $error("capture during execute");
`endif

endmodule
`default_nettype wire

[rtl/spq_dp.sv]
// Sorted entry array, request and result registers of the priority queue.
`default_nettype none
module spq_dp
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dp_cmd_t   cmd,
    input  wire req_beat_t req,
    output rsp_beat_t      rsp
);

    req_beat_t                req_reg;
    rsp_beat_t                rsp_reg;
    rsp_beat_t                rsp_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [PRIO_W-1:0]        prio_reg [DEPTH];
    logic [PRIO_W-1:0]        prio_next [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_reg [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_next [DEPTH];
    logic [PRIO_W-1:0]        prio_from_lo [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_from_lo [DEPTH];
    logic [PRIO_W-1:0]        prio_from_hi [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_from_hi [DEPTH];

    logic [DEPTH-1:0] vld;
    logic [DEPTH-1:0] le;
    logic [DEPTH-1:0] lt;
    logic [DEPTH-1:0] le_prev;
    logic [DEPTH-1:0] lt_prev;
    logic [DEPTH-1:0] rm;
    logic [DEPTH-1:0] shift_dn;
    logic             empty;
    logic             full;
    logic             push_ok;
    logic             pop_hit;
    logic [PAYLOAD_WIDTH-1:0] sel_pay;
    logic [PRIO_W-1:0]        sel_prio;

    // per-cell compares
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            vld[i] = (CNT_W'(i) < count_reg);
            le[i]  = vld[i] && (prio_reg[i] <= req_reg.priority_req);
            lt[i]  = vld[i] && (prio_reg[i] < req_reg.priority_req);
        end
        le_prev[0] = 1'b1;
        lt_prev[0] = 1'b1;
        for (int i = 1; i < DEPTH; i++)
        begin
            le_prev[i] = le[i-1];
            lt_prev[i] = lt[i-1];
        end
    end

    // pick the entry to remove and the cells that close the gap
    always_comb
    begin
        empty   = (count_reg == '0);
        full    = (count_reg == CNT_W'(DEPTH));
        push_ok = (req_reg.op == OP_PUSH) && !full;
        rm      = '0;
        shift_dn = '0;
        unique case (req_reg.op)
            OP_PUSH:
            begin
                rm = '0;
            end
            OP_POP_HEAD:
            begin
                rm[0]    = !empty;
                shift_dn = '1;
            end
            OP_POP_AT_MOST:
            begin
                rm[0]    = !empty && le[0];
                shift_dn = '1;
            end
            OP_POP_EXACT:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    rm[i]       = vld[i] && (prio_reg[i] == req_reg.priority_req) && lt_prev[i];
                    shift_dn[i] = !lt[i];
                end
            end
            default:
            begin
                rm = '0;
            end
        endcase
        pop_hit  = |rm;
        sel_pay  = '0;
        sel_prio = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_pay  = sel_pay | (pay_reg[i] & {PAYLOAD_WIDTH{rm[i]}});
            sel_prio = sel_prio | (prio_reg[i] & {PRIO_W{rm[i]}});
        end
    end

    // next cell contents
    always_comb
    begin
        // neighbor sources: from below for an insert, from above for a removal
        prio_from_lo[0] = req_reg.priority_req;
        pay_from_lo[0]  = req_reg.payload;
        for (int i = 1; i < DEPTH; i++)
        begin
            prio_from_lo[i] = prio_reg[i-1];
            pay_from_lo[i]  = pay_reg[i-1];
        end
        prio_from_hi[DEPTH-1] = prio_reg[DEPTH-1];
        pay_from_hi[DEPTH-1]  = pay_reg[DEPTH-1];
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            prio_from_hi[i] = prio_reg[i+1];
            pay_from_hi[i]  = pay_reg[i+1];
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            prio_next[i] = prio_reg[i];
            pay_next[i]  = pay_reg[i];
            if (push_ok && !le[i])
            begin
                if (le_prev[i])
                begin
                    prio_next[i] = req_reg.priority_req;
                    pay_next[i]  = req_reg.payload;
                end
                else
                begin
                    prio_next[i] = prio_from_lo[i];
                    pay_next[i]  = pay_from_lo[i];
                end
            end
            else if (pop_hit && shift_dn[i])
            begin
                prio_next[i] = prio_from_hi[i];
                pay_next[i]  = pay_from_hi[i];
            end
        end
    end

    // count and result
    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_hit)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        rsp_next.out_payload  = sel_pay;
        rsp_next.out_priority = sel_prio;
        rsp_next.fill         = count_next;
        priority if (push_ok || pop_hit)
        begin
            rsp_next.status = ST_OK;
        end
        else if (req_reg.op == OP_PUSH)
        begin
            rsp_next.status = ST_FULL;
        end
        else
        begin
            rsp_next.status = ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                prio_reg[i] <= prio_next[i];
                pay_reg[i]  <= pay_next[i];
            end
        end
    end

    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && push_ok |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the queue");
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && empty && req_reg.op != OP_PUSH |=> rsp_reg.status == ST_EMPTY)
        else $error("pop on empty queue not flagged");
    a_single_removal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> $onehot0(rm))
        else $error("more than one entry selected for removal");
`endif

endmodule
`default_nettype wire

[rtl/stable_priority_queue.sv]
// Top level of the stable priority queue: controller plus sorted-array datapath.
// A taken request beat is registered, then executed into the result register, which holds the result beat valid.
// The next request is taken in the cycle the previous result beat leaves,
//   so a stalled result holds off new requests.
// Reset (rst_n low, asynchronous) empties the queue and the handshake; entry
//   storage is not cleared, only entries below the fill count are ever read.
`default_nettype none
module stable_priority_queue
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_beat_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_beat_t      rsp
);

    dp_cmd_t cmd;

    // Sequence capture, execute and result hand-off.
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // Hold the sorted entries; insert, remove and shift on execute.
    spq_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire
